// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL of the table interpolator.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// implication in the same cycle
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("implication check failed");
// implication in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, a, c)
`define ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

// ----- design/plt_pkg.sv -----
// Types and codes for the piecewise-linear table interpolator.
// No dependencies.
package plt_pkg;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } plt_op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_EQUAL = 2'd2,
    ST_SAT   = 2'd3
  } plt_status_t;

  typedef enum logic {
    UOP_MUL = 1'b0,
    UOP_DIV = 1'b1
  } plt_uop_t;

  typedef struct packed {
    logic     start;
    plt_uop_t op;
  } plt_ucmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } plt_ustat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD0,
    S_RD_LAST,
    S_CHK,
    S_SRCH_ADDR,
    S_SRCH_CMP,
    S_SEG_I,
    S_SEG_J,
    S_SEG_CAP,
    S_DIFF,
    S_MUL_GO,
    S_MUL,
    S_DIV_GO,
    S_DIV,
    S_ROUND,
    S_FIN
  } plt_state_t;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

endpackage

// ----- design/plt_table.sv -----
// Key and value memories of the interpolator, one write and one read port.
// Depends on nothing; read data is registered.
module plt_table #(
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  logic                 clk,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic signed [31:0]   wr_key,
  input  logic signed [31:0]   wr_val,
  input  logic [AW-1:0]        rd_addr,
  output logic signed [31:0]   rd_key,
  output logic signed [31:0]   rd_val
);

  logic signed [31:0] key_mem [DEPTH];
  logic signed [31:0] val_mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rd_key <= key_mem[rd_addr];
    rd_val <= val_mem[rd_addr];
  end

endmodule

// ----- design/plt_muldiv.sv -----
// Shared serial multiply / restoring divide unit built round one 33-bit adder.
// Depends on plt_pkg. Multiply: 32 steps; divide of the product: 64 steps.
module plt_muldiv (
  input  logic               clk,
  input  logic               rst_n,
  input  plt_pkg::plt_ucmd_t cmd,
  input  logic [31:0]        opa,
  input  logic [31:0]        opb,
  output plt_pkg::plt_ustat_t stat,
  output logic [63:0]        quo,
  output logic [31:0]        rem
);
  import plt_pkg::*;

  logic [32:0] acc_r, acc_nxt;
  logic [63:0] sh_r, sh_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  plt_uop_t    op_r, op_nxt;
  logic [32:0] add_x, add_y;
  logic        cin;
  logic [33:0] sum;
  logic [32:0] div_t;

  // one shared adder: add for multiply, subtract for divide
  always_comb begin
    div_t = {acc_r[31:0], sh_r[63]};
    if (op_r == UOP_DIV) begin
      add_x = div_t;
      add_y = ~{1'b0, opa};
      cin   = 1'b1;
    end else begin
      add_x = acc_r;
      add_y = sh_r[0] ? {1'b0, opa} : 33'd0;
      cin   = 1'b0;
    end
    sum = {1'b0, add_x} + {1'b0, add_y} + {33'd0, cin};
  end

  // step control
  always_comb begin
    acc_nxt  = acc_r;
    sh_nxt   = sh_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    op_nxt   = op_r;
    done_nxt = 1'b0;
    if (cmd.start) begin
      busy_nxt = 1'b1;
      op_nxt   = cmd.op;
      if (cmd.op == UOP_MUL) begin
        acc_nxt = 33'd0;
        sh_nxt  = {32'd0, opb};
        cnt_nxt = 6'd31;
      end else begin
        acc_nxt = 33'd0;
        sh_nxt  = {acc_r[31:0], sh_r[31:0]};
        cnt_nxt = 6'd63;
      end
    end else if (busy_r) begin
      if (op_r == UOP_MUL) begin
        acc_nxt = {1'b0, sum[32:1]};
        sh_nxt  = {32'd0, sum[0], sh_r[31:1]};
      end else begin
        acc_nxt = sum[33] ? sum[32:0] : div_t;
        sh_nxt  = {sh_r[62:0], sum[33]};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= UOP_MUL;
      cnt_r  <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    sh_r  <= sh_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quo       = sh_r;
  assign rem       = acc_r[31:0];

endmodule

// ----- design/piecewise_linear_table_interp.sv -----
// Piecewise-linear table interpolator: sequencer, search and result logic.
// Depends on plt_pkg, plt_table, plt_muldiv and assert_macros.svh.
//
// Input words (in_*): in_tuser is the opcode. A write word stores one key and
// value in a slot and gives no result, and the sequencer stays idle. A query word
// searches the table for its segment and gives exactly one output word.
// Output words (out_*): out_tdata is the Q16.16 result, out_tuser the status
// (ok, empty table, equal keys, saturated).
// cfg_*: the entry count register, always ready; write it only while idle.
// A query first reads the end entries, then takes s bisection steps (none
// outside the key span, up to 8 at 256 entries), each an address and a compare
// state on the single registered memory read port, then a serial multiply and
// a serial divide on the shared add/subtract unit, and rounds the result. An
// empty table goes straight to the final step, a single entry after its read,
// and equal keys skip the multiply and divide.
// One query is worked on at a time; in_tready is high only while idle. The
// result waits in an output register, and the next word is taken while it
// waits; a stalled receiver holds the sequencer at its final step. Reset
// clears the count and control; table contents stay undefined until written.
module piecewise_linear_table_interp #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [103:0] in_tdata,   // entry_index[7:0], entry_key, entry_value, query_key
  input  logic         in_tuser,   // opcode
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [31:0]  out_tdata,  // result_value
  output logic [1:0]   out_tuser,  // status
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [8:0]   cfg_data    // entry_count
);
  import plt_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int NW = AW + 1;
  localparam int CW = (NW > 9) ? NW : 9;

  plt_state_t state_r, state_nxt;

  logic [8:0]          count_r;
  logic [CW-1:0]       n_full;
  logic [NW-1:0]       n_act;
  logic signed [31:0]  q_r;
  logic                lt0_r;
  logic [AW-1:0]       lo_r, hi_r, i_r;
  logic [AW:0]         mid_sum;
  logic [AW-1:0]       mid;
  logic [AW-1:0]       last_idx;
  logic [AW-1:0]       new_lo, new_hi;
  logic signed [31:0]  k1_r, v1_r;
  logic                neg_r;
  logic [31:0]         dv_mag_r, dq_mag_r, dk_mag_r;
  logic signed [32:0]  dv, dq, dk;
  logic signed [31:0]  res_r;
  plt_status_t         st_r;
  logic                out_valid_r;

  logic                in_acc;
  logic                wr_en;
  logic [AW-1:0]       rd_addr;
  logic signed [31:0]  rd_key, rd_val;
  plt_ucmd_t           ucmd;
  plt_ustat_t          ustat;
  logic [31:0]         u_opa;
  logic [63:0]         quo;
  logic [31:0]         rem;
  logic                rnd;
  logic [64:0]         qr;
  logic                q_big;
  logic signed [36:0]  r37;

  // payload fields
  logic [7:0]          f_index;
  logic signed [31:0]  f_key, f_val, f_query;
  assign f_index = in_tdata[7:0];
  assign f_key   = in_tdata[39:8];
  assign f_val   = in_tdata[71:40];
  assign f_query = in_tdata[103:72];

  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  // count in use, limited to the depth
  assign n_full   = CW'(count_r);
  assign n_act    = (n_full > CW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(n_full);
  assign last_idx = AW'(n_act - NW'(1));

  // writes to slots beyond the depth are dropped
  assign wr_en = in_acc && (plt_op_t'(in_tuser) == OP_WRITE)
                 && (32'(f_index) < 32'(TABLE_DEPTH));

  plt_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(f_index)),
    .wr_key  (f_key),
    .wr_val  (f_val),
    .rd_addr (rd_addr),
    .rd_key  (rd_key),
    .rd_val  (rd_val)
  );

  plt_muldiv u_muldiv (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (ucmd),
    .opa   (u_opa),
    .opb   (dq_mag_r),
    .stat  (ustat),
    .quo   (quo),
    .rem   (rem)
  );

  // bisection step
  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[AW:1];
  assign new_lo  = (rd_key <= q_r) ? mid : lo_r;
  assign new_hi  = (rd_key <= q_r) ? hi_r : mid;

  // segment differences
  assign dv = 33'(rd_val) - 33'(v1_r);
  assign dq = 33'(q_r) - 33'(k1_r);
  assign dk = 33'(rd_key) - 33'(k1_r);

  // rounding and final add
  assign rnd   = ({rem, 1'b0} >= {1'b0, dk_mag_r});
  assign qr    = {1'b0, quo} + {64'd0, rnd};
  assign q_big = (qr > 65'h4_0000_0000);
  assign r37   = neg_r ? (37'(v1_r) - 37'({2'b00, qr[34:0]}))
                       : (37'(v1_r) + 37'({2'b00, qr[34:0]}));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && plt_op_t'(in_tuser) == OP_QUERY) begin
          state_nxt = (n_act == NW'(0)) ? S_FIN : S_RD0;
        end
      end
      S_RD0:       state_nxt = S_RD_LAST;
      S_RD_LAST:   state_nxt = (n_act == NW'(1)) ? S_FIN : S_CHK;
      S_CHK: begin
        if (lt0_r || q_r >= rd_key || n_act == NW'(2)) begin
          state_nxt = S_SEG_I;
        end else begin
          state_nxt = S_SRCH_ADDR;
        end
      end
      S_SRCH_ADDR: state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        state_nxt = ((new_hi - new_lo) > AW'(1)) ? S_SRCH_ADDR : S_SEG_I;
      end
      S_SEG_I:     state_nxt = S_SEG_J;
      S_SEG_J:     state_nxt = S_SEG_CAP;
      S_SEG_CAP:   state_nxt = S_DIFF;
      S_DIFF:      state_nxt = (k1_r == rd_key) ? S_FIN : S_MUL_GO;
      S_MUL_GO:    state_nxt = S_MUL;
      S_MUL:       state_nxt = ustat.done ? S_DIV_GO : S_MUL;
      S_DIV_GO:    state_nxt = S_DIV;
      S_DIV:       state_nxt = ustat.done ? S_ROUND : S_DIV;
      S_ROUND:     state_nxt = S_FIN;
      S_FIN:       state_nxt = (!out_valid_r || out_tready) ? S_IDLE : S_FIN;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_tready = 1'b0;
    rd_addr   = '0;
    ucmd      = '{start: 1'b0, op: UOP_MUL};
    u_opa     = dv_mag_r;
    unique case (state_r)
      S_IDLE:      in_tready = 1'b1;
      S_RD_LAST:   rd_addr = last_idx;
      S_SRCH_ADDR: rd_addr = mid;
      S_SEG_I:     rd_addr = i_r;
      S_SEG_J,
      S_SEG_CAP:   rd_addr = i_r + AW'(1);
      S_MUL_GO:    ucmd = '{start: 1'b1, op: UOP_MUL};
      S_DIV_GO: begin
        ucmd  = '{start: 1'b1, op: UOP_DIV};
        u_opa = dk_mag_r;
      end
      S_DIV:       u_opa = dk_mag_r;
      default:     rd_addr = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= 9'd0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && cfg_ready) begin
        count_r <= cfg_data;
      end
      if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        q_r   <= f_query;
        res_r <= 32'sd0;
        st_r  <= ST_EMPTY;
      end
      S_RD_LAST: begin
        lt0_r <= (q_r < rd_key);
        res_r <= rd_val;
        st_r  <= ST_OK;
      end
      S_CHK: begin
        lo_r <= '0;
        hi_r <= last_idx;
        if (lt0_r || n_act == NW'(2)) begin
          i_r <= '0;
        end else if (q_r >= rd_key) begin
          i_r <= last_idx - AW'(1);
        end
      end
      S_SRCH_CMP: begin
        lo_r <= new_lo;
        hi_r <= new_hi;
        i_r  <= (new_lo == last_idx) ? new_lo - AW'(1) : new_lo;
      end
      S_SEG_J: begin
        k1_r <= rd_key;
        v1_r <= rd_val;
      end
      S_DIFF: begin
        // rd_key/rd_val hold the upper end of the segment here
        dv_mag_r <= dv[32] ? 32'(-dv) : dv[31:0];
        dq_mag_r <= dq[32] ? 32'(-dq) : dq[31:0];
        dk_mag_r <= dk[32] ? 32'(-dk) : dk[31:0];
        neg_r    <= (dv[32] ^ dq[32] ^ dk[32]) && (dv != 33'sd0) && (dq != 33'sd0);
        res_r    <= 32'sd0;
        st_r     <= ST_EQUAL;
      end
      S_ROUND: begin
        if (q_big) begin
          res_r <= neg_r ? VAL_MIN : VAL_MAX;
          st_r  <= ST_SAT;
        end else if (r37 > 37'(VAL_MAX)) begin
          res_r <= VAL_MAX;
          st_r  <= ST_SAT;
        end else if (r37 < 37'(VAL_MIN)) begin
          res_r <= VAL_MIN;
          st_r  <= ST_SAT;
        end else begin
          res_r <= r37[31:0];
          st_r  <= ST_OK;
        end
      end
      default: begin
        q_r <= q_r;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (state_r == S_FIN && (!out_valid_r || out_tready)) begin
      out_tdata <= res_r;
      out_tuser <= st_r;
    end
  end

  assign out_tvalid = out_valid_r;

`include "assert_macros.svh"

  `ASSERT_IMPL(a_idle_unit, clk, rst_n, state_r == S_IDLE, !ustat.busy)
  `ASSERT_IMPL(a_search_span, clk, rst_n, state_r == S_SRCH_CMP, lo_r < hi_r)
  `ASSERT_IMPL(a_sat_bound, clk, rst_n, out_tvalid && out_tuser == ST_SAT,
               out_tdata == VAL_MAX || out_tdata == VAL_MIN)
  `ASSERT_IMPL(a_err_zero, clk, rst_n,
               out_tvalid && (out_tuser == ST_EMPTY || out_tuser == ST_EQUAL),
               out_tdata == 32'd0)
  `ASSERT_NEXT(a_fin_out, clk, rst_n, state_r == S_FIN && state_nxt == S_IDLE,
               out_tvalid)

endmodule
